// ===== sv/sicm_pkg.sv =====
// shared types and constants for the sorted list intersection counter
// no dependencies; imported by sicm_ram users, sicm_ctrl and the top level
package sicm_pkg;

  localparam int unsigned EXTRACT_DEPTH = 4096;

  localparam int unsigned VAL_W = 31;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned AW    = (EXTRACT_DEPTH > 1) ? $clog2(EXTRACT_DEPTH) : 1;
  localparam int unsigned LEN_W = $clog2(EXTRACT_DEPTH + 1);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_COLUMN = 1'b1;

  // request from the controller to the extract store
  typedef struct packed {
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic [AW-1:0]    raddr;
  } mem_req_t;

  // finished total handed to the output stage
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] total;
    logic             sat;
  } res_t;

endpackage

// ===== sv/sicm_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module sicm_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 31,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sicm_ctrl.sv =====
// load and merge scan controller: list length, scan pointer, saturating count
// depends on sicm_pkg; drives the extract store through a mem_req_t
module sicm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [sicm_pkg::VAL_W-1:0] value_i,
  input  logic                      first_entry_i,
  input  logic                      last_in_column_i,
  input  logic                      last_overall_i,
  output sicm_pkg::mem_req_t        mem_req_o,
  input  logic [sicm_pkg::VAL_W-1:0] mem_rdata_i,
  input  logic                      out_free_i,
  output sicm_pkg::res_t            res_o
);
  import sicm_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0]       state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             sat_q, sat_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             last_col_q, last_col_d;
  logic             last_all_q, last_all_d;

  logic             in_acc;
  logic [LEN_W-1:0] len_base;
  logic             entry_ok;
  logic             entry_less;
  logic             entry_eq;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign len_base   = first_entry_i ? '0 : len_q;
  assign entry_ok   = (pos_q < len_q);
  assign entry_less = entry_ok && (mem_rdata_i < val_q);
  assign entry_eq   = entry_ok && (mem_rdata_i == val_q);

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    pos_d      = pos_q;
    count_d    = count_q;
    sat_d      = sat_q;
    val_d      = val_q;
    last_col_d = last_col_q;
    last_all_d = last_all_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = len_base[AW-1:0];
    mem_req_o.wdata = value_i;
    res_o.valid = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_LOAD) begin
            if (first_entry_i) begin
              pos_d   = '0;
              count_d = '0;
              sat_d   = 1'b0;
            end
            len_d = len_base;
            if (len_base < LEN_W'(EXTRACT_DEPTH)) begin
              mem_req_o.we = 1'b1;
              len_d        = len_base + LEN_W'(1);
            end
          end else begin
            val_d      = value_i;
            last_col_d = last_in_column_i;
            last_all_d = last_overall_i;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (entry_less) begin
          // step past a smaller entry, next one read this cycle
          pos_d = pos_q + LEN_W'(1);
        end else if (!last_all_q || out_free_i) begin
          if (entry_eq) begin
            pos_d = pos_q + LEN_W'(1);
            if (count_q != '1) begin
              count_d = count_q + CNT_W'(1);
            end
            sat_d = sat_q || (count_d == '1);
          end
          if (last_col_q || last_all_q) begin
            pos_d = '0;
          end
          res_o.valid = last_all_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // read address follows the next pointer so data lines up with pos_q
    mem_req_o.raddr = pos_d[AW-1:0];

    res_o.total = count_d;
    res_o.sat   = sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      pos_q   <= '0;
      count_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    last_col_q <= last_col_d;
    last_all_q <= last_all_d;
  end

endmodule

// ===== sv/sorted_intersection_count_merge.sv =====
// top level of the sorted list intersection counter
// depends on sicm_pkg, sicm_ram and sicm_ctrl

// Counts how many row indices of a stream of sparse columns appear in a
// sorted extract list held in an on-chip store of EXTRACT_DEPTH entries.
// A load transaction (func 0) appends one entry to the store; first_entry
// restarts the list and clears the count, the saturation flag and the scan
// pointer; loads beyond the store depth are dropped. A column transaction
// (func 1) stalls the input while the scan pointer steps over the stored
// entries that are smaller than the incoming index: the single read port
// of the store delivers one entry per cycle. The pointer only moves forward
// within a column. An equal entry adds one to a 32-bit count that sticks at
// its maximum and raises saturated. On last_overall the total leaves through
// an output register, which may hold one result while the next transactions
// are taken; the count keeps accumulating after emission.
module sorted_intersection_count_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [sicm_pkg::VAL_W-1:0] value_i,
  input  logic                       first_entry_i,
  input  logic                       last_in_column_i,
  input  logic                       last_overall_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sicm_pkg::CNT_W-1:0] total_matches_o,
  output logic                       saturated_o
);
  import sicm_pkg::*;

  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  res_t             res;
  logic             out_free;

  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] total_q;
  logic             sat_q;

  // extract list store
  sicm_ram #(
    .Depth (EXTRACT_DEPTH),
    .Width (VAL_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // load path and merge scan
  sicm_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .value_i          (value_i),
    .first_entry_i    (first_entry_i),
    .last_in_column_i (last_in_column_i),
    .last_overall_i   (last_overall_i),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata),
    .out_free_i       (out_free),
    .res_o            (res)
  );

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload only moves when a new total is emitted
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      total_q <= res.total;
      sat_q   <= res.sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign total_matches_o = total_q;
  assign saturated_o     = sat_q;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the sorted list intersection counter
// depends on sicm_pkg and the sorted_intersection_count_merge top level
// directed corner cases, random load and column streams, a long output hold

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sicm_pkg::*;

  // one input transaction plus the number of idle cycles offered before it
  typedef struct packed {
    logic             func;
    logic [VAL_W-1:0] value;
    logic             first;
    logic             last_col;
    logic             last_all;
    logic [7:0]       gap;
  } scan_item_t;

  // one emitted total
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic             sat;
  } total_t;

  localparam int unsigned IDLE_MAX   = 18;
  localparam int unsigned HOLD_LEN   = 600;
  localparam int unsigned STUCK_MAX  = 20000;
  localparam int unsigned RAND_ITEMS = 1830;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic             in_stall_o;
  logic             func_i           = FUNC_LOAD;
  logic [VAL_W-1:0] value_i          = '0;
  logic             first_entry_i    = 1'b0;
  logic             last_in_column_i = 1'b0;
  logic             last_overall_i   = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i      = 1'b0;
  logic [CNT_W-1:0] total_matches_o;
  logic             saturated_o;

  sorted_intersection_count_merge dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .value_i          (value_i),
    .first_entry_i    (first_entry_i),
    .last_in_column_i (last_in_column_i),
    .last_overall_i   (last_overall_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .total_matches_o  (total_matches_o),
    .saturated_o      (saturated_o)
  );

  // 2 ns period
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // intersection predictor: its own copy of the extract list, scan pointer
  // and saturating match count
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] extract_list [EXTRACT_DEPTH];
  int unsigned      list_len     = 0;
  int unsigned      scan_ptr     = 0;
  logic [CNT_W-1:0] hit_count    = '0;
  logic             hit_sat      = 1'b0;
  int unsigned      loads_dropped = 0;
  int unsigned      longest_list  = 0;

  scan_item_t pending_q[$];   // transactions still to be offered
  total_t     totals_q[$];    // totals the block still owes us

  // apply one accepted transaction and queue the total it emits, if any
  task automatic count_step(input logic f, input logic [VAL_W-1:0] v,
                            input logic fe, input logic lc, input logic la);
    total_t t;
    if (f == FUNC_LOAD) begin
      // on a load only first_entry matters, the column flags are ignored
      if (fe) begin
        list_len  = 0;
        scan_ptr  = 0;
        hit_count = '0;
        hit_sat   = 1'b0;
      end
      if (list_len < EXTRACT_DEPTH) begin
        extract_list[list_len] = v;
        list_len++;
        if (list_len > longest_list) longest_list = list_len;
      end else begin
        loads_dropped++;    // store full, entry lost
      end
    end else begin
      // walk past smaller entries; the pointer never moves back in a column
      while (scan_ptr < list_len && extract_list[scan_ptr] < v) scan_ptr++;
      if (scan_ptr < list_len && extract_list[scan_ptr] == v) begin
        if (hit_count != '1) hit_count++;
        if (hit_count == '1) hit_sat = 1'b1;
        scan_ptr++;
      end
      if (lc || la) scan_ptr = 0;
      if (la) begin
        t.total = hit_count;
        t.sat   = hit_sat;
        totals_q = {totals_q, t};
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  int unsigned errors = 0;

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    $display("mismatch: %s, got %h, expected %h, at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: samples both handshakes at the rising edge, checks the output
  // transaction before feeding the input transaction to the predictor
  // ---------------------------------------------------------------------------
  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned items_seen   = 0;
  int unsigned results_seen = 0;
  total_t      want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_taken = out_valid_o && !out_stall_i;
      in_taken  = in_valid_i && !in_stall_o;
      if (out_taken) begin
        if (totals_q.size() == 0) begin
          report_mismatch("total with nothing outstanding", total_matches_o, '0);
        end else begin
          want = totals_q.pop_front();
          if (total_matches_o !== want.total)
            report_mismatch("total_matches", total_matches_o, want.total);
          if (saturated_o !== want.sat)
            report_mismatch("saturated", CNT_W'(saturated_o), CNT_W'(want.sat));
        end
        results_seen++;
      end
      if (in_taken) begin
        count_step(func_i, value_i, first_entry_i, last_in_column_i, last_overall_i);
        items_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers the queued transactions at the falling edge, each after
  // its own number of idle cycles; a stalled payload is held unchanged
  // ---------------------------------------------------------------------------
  scan_item_t  cur_item;
  int unsigned offer_wait = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      offer_wait = 0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_q.size() != 0 && offer_wait >= pending_q[0].gap) begin
        cur_item = pending_q.pop_front();
        func_i           <= cur_item.func;
        value_i          <= cur_item.value;
        first_entry_i    <= cur_item.first;
        last_in_column_i <= cur_item.last_col;
        last_overall_i   <= cur_item.last_all;
        in_valid_i       <= 1'b1;
        offer_wait = 0;
      end else begin
        in_valid_i <= 1'b0;
        offer_wait++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long hold: once started the receiver refuses every total while hold_left
  // counts down from HOLD_LEN so that the output register fills and the block
  // stalls its input
  logic        hold_start = 1'b0;
  logic        hold_done  = 1'b0;
  int unsigned hold_left  = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (hold_start && !hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: per total a random number of stall cycles, with stretches of
  // no stalling chosen every forty totals
  // ---------------------------------------------------------------------------
  int unsigned rx_wait  = 0;
  logic        rx_quiet = 1'b0;
  int unsigned rx_count = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        rx_count++;
        if (rx_count % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        rx_wait = rx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (out_valid_o && rx_wait != 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too many cycles in a row without any transaction ends the run;
  // the limit covers a full-store scan plus the long hold several times over
  // ---------------------------------------------------------------------------
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_MAX) begin
      $display("timeout: no transaction for %0d cycles, %0d totals outstanding",
               stuck_cycles, totals_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  logic        seq_quiet    = 1'b0;   // no idle cycles for the items being built
  int unsigned items_queued = 0;

  task automatic push_item(input logic f, input logic [VAL_W-1:0] v, input logic fe,
                           input logic lc, input logic la);
    scan_item_t it;
    it.func     = f;
    it.value    = v;
    it.first    = fe;
    it.last_col = lc;
    it.last_all = la;
    it.gap      = seq_quiet ? 8'd0 : 8'($urandom_range(0, IDLE_MAX));
    pending_q = {pending_q, it};
    items_queued++;
  endtask

  // one random sequence: mostly a sorted extract list followed by a few
  // sorted columns around it, sometimes noise or deliberately broken order
  task automatic add_sequence();
    int unsigned      kind;
    int unsigned      n_load;
    int unsigned      n_col;
    int unsigned      n_idx;
    logic             unsorted;
    logic             emit;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] v;
    kind      = $urandom_range(0, 99);
    seq_quiet = ($urandom_range(0, 3) == 0);
    if (kind < 10) begin
      // noise: any kind, any value, any flags
      repeat ($urandom_range(1, 8)) begin
        v = VAL_W'($urandom);
        push_item(1'($urandom_range(0, 1)), v, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      return;
    end
    base   = VAL_W'($urandom_range(0, 32'h7FFF_F000));
    n_load = 0;
    // without loads the columns run against the list left from before
    if (kind >= 20) begin
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      v = base;
      for (int i = 0; i < n_load; i++) begin
        // a missing restart appends to the old list, out of order
        push_item(FUNC_LOAD, v, (i == 0) && ($urandom_range(0, 9) != 0),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        v = v + VAL_W'($urandom_range(1, 4));
      end
    end
    n_col = $urandom_range(1, 4);
    emit  = ($urandom_range(0, 9) != 0);
    for (int c = 0; c < n_col; c++) begin
      unsorted = ($urandom_range(0, 19) == 0);
      n_idx    = $urandom_range(1, 8);
      v        = (base >= 3) ? base - VAL_W'($urandom_range(0, 3)) : base;
      for (int j = 0; j < n_idx; j++) begin
        if (unsorted) v = base + VAL_W'($urandom_range(0, 4 * n_load + 4));
        push_item(FUNC_COLUMN, v, 1'($urandom_range(0, 1)), j == n_idx - 1,
                  emit && (c == n_col - 1) && (j == n_idx - 1));
        v = v + VAL_W'($urandom_range(1, 3));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_q.size() != 0 || in_valid_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: empty list straight after reset, count stays zero
    push_item(FUNC_COLUMN, '0, 1'b0, 1'b0, 1'b1);
    // list at the value extremes; column flags on loads are ignored
    push_item(FUNC_LOAD, '0, 1'b1, 1'b0, 1'b0);
    push_item(FUNC_LOAD, 31'd5, 1'b0, 1'b1, 1'b0);
    push_item(FUNC_LOAD, 31'h7FFF_FFFE, 1'b0, 1'b0, 1'b1);
    push_item(FUNC_LOAD, 31'h7FFF_FFFF, 1'b0, 1'b1, 1'b1);
    // first_entry on a column is ignored; a miss between two hits
    push_item(FUNC_COLUMN, '0, 1'b1, 1'b0, 1'b0);
    push_item(FUNC_COLUMN, 31'd3, 1'b0, 1'b0, 1'b0);
    push_item(FUNC_COLUMN, 31'd5, 1'b0, 1'b0, 1'b0);
    push_item(FUNC_COLUMN, 31'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
    // index below the pointer after a hit matches nothing
    push_item(FUNC_COLUMN, 31'h7FFF_FFFE, 1'b0, 1'b0, 1'b0);
    push_item(FUNC_COLUMN, 31'd5, 1'b0, 1'b0, 1'b1);
    // count carries on after a total has been emitted
    push_item(FUNC_COLUMN, 31'd5, 1'b0, 1'b0, 1'b1);
    // restart with an unsorted list, kept in arrival order
    push_item(FUNC_LOAD, 31'd10, 1'b1, 1'b0, 1'b0);
    push_item(FUNC_LOAD, 31'd7, 1'b0, 1'b0, 1'b0);
    push_item(FUNC_LOAD, 31'd12, 1'b0, 1'b0, 1'b0);
    push_item(FUNC_COLUMN, 31'd7, 1'b0, 1'b0, 1'b0);
    push_item(FUNC_COLUMN, 31'd12, 1'b0, 1'b0, 1'b1);
    wait_drained();

    // random part, opened by the long output hold
    @(negedge clk_i);
    hold_start = 1'b1;
    @(posedge clk_i);
    items_queued = 0;
    while (items_queued < RAND_ITEMS) add_sequence();
    wait_drained();

    // let the last totals arrive, then watch for stray ones
    while (totals_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);

    $display("covered %0d input transactions and %0d checked totals",
             items_seen, results_seen);
    $display("longest extract list %0d entries, %0d loads dropped on a full store",
             longest_list, loads_dropped);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sorted_intersection_count_merge.f =====
sv/sicm_pkg.sv
sv/sicm_ram.sv
sv/sicm_ctrl.sv
sv/sorted_intersection_count_merge.sv
dv/testbench.sv
